// ===== sv/ascii_hex_frame_receiver_unit_assert.svh =====
// Assertion macros for the ASCII hex frame receiver checker.
// Depends on nothing; taken in by the checker file.
`ifndef ASCII_HEX_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define ASCII_HEX_FRAME_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define AHFR_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("ahfr check failed");

// next-cycle implication, quiet while reset is high
`define AHFR_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("ahfr check failed");

// next-cycle implication, checked through reset as well
`define AHFR_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("ahfr check failed");

`endif

// ===== sv/ahfr_pkg.sv =====
// Package for the ASCII hex frame receiver: word types, status and register
// codes, reset values and the hex and command range helpers.
package ahfr_pkg;

  localparam int FRAME_LEN        = 6;
  localparam int BUFFER_SIZE_DEF  = 16;
  localparam int STORE_IDX_W      = $clog2(FRAME_LEN);
  localparam int CFG_IDX_W        = 3;

  localparam logic [7:0] START_BYTE_RST   = 8'h02;
  localparam logic [7:0] END_BYTE_RST     = 8'h03;
  localparam logic [7:0] OWN_ADDRESS_RST  = 8'h00;
  localparam logic [7:0] PEER_ADDRESS_RST = 8'h00;
  localparam logic [1:0] CMD_CLASS_RST    = 2'd3;

  localparam logic [7:0] ASCII_LOWER_A = 8'd97;
  localparam logic [7:0] ASCII_UPPER_A = 8'd65;
  localparam logic [7:0] ASCII_ZERO    = 8'd48;

  localparam logic [7:0] CMD_LOW_MIN  = 8'h01;
  localparam logic [7:0] CMD_LOW_MAX  = 8'h1F;
  localparam logic [7:0] CMD_MID_MIN  = 8'h20;
  localparam logic [7:0] CMD_MID_MAX  = 8'h3F;
  localparam logic [7:0] CMD_HIGH_MIN = 8'h40;
  localparam logic [7:0] CMD_HIGH_MAX = 8'h5F;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LENGTH   = 3'd1,
    ST_ADDRESS  = 3'd2,
    ST_CMD_HEX  = 3'd3,
    ST_DATA_HEX = 3'd4,
    ST_RANGE    = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE    = 3'd0,
    REG_END_BYTE      = 3'd1,
    REG_OWN_ADDRESS   = 3'd2,
    REG_PEER_ADDRESS  = 3'd3,
    REG_COMMAND_CLASS = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLASS_LOW  = 2'd0,
    CLASS_MID  = 2'd1,
    CLASS_HIGH = 2'd2,
    CLASS_ANY  = 2'd3
  } cmd_class_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_word_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] command;
    logic [7:0] payload;
  } res_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [7:0]           reg_value;
  } cfg_word_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nibble_t;

  function automatic nibble_t hex_nibble(input logic [7:0] c);
    nibble_t n;
    n = '{ok: 1'b0, val: 4'd0};
    if (c >= ASCII_LOWER_A && c < ASCII_LOWER_A + 8'd6) begin
      n = '{ok: 1'b1, val: 4'(c - ASCII_LOWER_A + 8'd10)};
    end else if (c >= ASCII_UPPER_A && c < ASCII_UPPER_A + 8'd6) begin
      n = '{ok: 1'b1, val: 4'(c - ASCII_UPPER_A + 8'd10)};
    end else if (c >= ASCII_ZERO && c < ASCII_ZERO + 8'd10) begin
      n = '{ok: 1'b1, val: 4'(c - ASCII_ZERO)};
    end
    return n;
  endfunction

  function automatic logic in_class(input logic [7:0] cmd, input logic [1:0] cls);
    logic hit;
    unique case (cmd_class_t'(cls))
      CLASS_LOW:  hit = (cmd >= CMD_LOW_MIN)  && (cmd <= CMD_LOW_MAX);
      CLASS_MID:  hit = (cmd >= CMD_MID_MIN)  && (cmd <= CMD_MID_MAX);
      CLASS_HIGH: hit = (cmd >= CMD_HIGH_MIN) && (cmd <= CMD_HIGH_MAX);
      default:    hit = 1'b1;
    endcase
    return hit;
  endfunction

endpackage

// ===== sv/ahfr_chan_if.sv =====
// Valid/ready channel carrying one word of a chosen packed type.
// Depends on nothing; word types come from ahfr_pkg at the instance.
interface ahfr_chan_if #(parameter type word_t = logic [7:0]) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ascii_hex_frame_receiver_unit.sv =====
// ASCII hex frame receiver, top level.
// Depends on ahfr_pkg and ahfr_chan_if.
//
// Channels: rx takes one received byte per word; res gives one result word
// (status, command, payload) per finished or failed frame; cfg writes the
// registers start_byte, end_byte, own_address, peer_address, command_class
// at indexes 0 to 4 (other indexes are ignored) and is always ready.
// Throughput: one rx word per cycle while rx is ready. The frame state and
// the six-byte store update in the cycle a byte is taken, and the parse of a
// closing byte is one pass of compare and hex decode logic into the result
// register, or into the skid register while a held result is not taken.
// Stall: a two-word output buffer (result register and skid register) parts
// the sides; rx stays ready while the skid register is empty, so bytes that
// give no result keep flowing while a result waits, and rx drops ready only
// when two results are held.
// Reset (rst, synchronous): registers return to their reset values, the
// receiver goes idle, both output words are emptied. The store is not
// cleared: a frame is parsed only after all six entries were written.
module ascii_hex_frame_receiver_unit
  import ahfr_pkg::*;
#(
  parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ahfr_chan_if.sink   rx,
  ahfr_chan_if.source res,
  ahfr_chan_if.sink   cfg
);

  localparam int CNT_W = $clog2(BUFFER_SIZE);

  logic [7:0] start_byte;
  logic [7:0] end_byte;
  logic [7:0] own_address;
  logic [7:0] peer_address;
  logic [1:0] command_class;

  logic             receiving, receiving_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       frame_store [FRAME_LEN];

  logic       out_valid, skid_valid;
  res_word_t  out_word, skid_word;

  logic       rx_byte_hit_start, rx_byte_hit_end;
  logic       accept, take, emit, store_wr;
  res_word_t  new_word;
  nibble_t    cmd_hi, cmd_lo, dat_hi, dat_lo;
  logic [7:0] cmd_val, dat_val;
  logic [7:0] b;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !skid_valid;
  assign res.valid = out_valid;
  assign res.data  = out_word;

  assign accept = rx.valid && rx.ready;
  assign take   = out_valid && res.ready;
  assign b      = rx.data.rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= START_BYTE_RST;
      end_byte      <= END_BYTE_RST;
      own_address   <= OWN_ADDRESS_RST;
      peer_address  <= PEER_ADDRESS_RST;
      command_class <= CMD_CLASS_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.data.reg_index))
        REG_START_BYTE:    start_byte    <= cfg.data.reg_value;
        REG_END_BYTE:      end_byte      <= cfg.data.reg_value;
        REG_OWN_ADDRESS:   own_address   <= cfg.data.reg_value;
        REG_PEER_ADDRESS:  peer_address  <= cfg.data.reg_value;
        REG_COMMAND_CLASS: command_class <= cfg.data.reg_value[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd_hi  = hex_nibble(frame_store[2]);
    cmd_lo  = hex_nibble(frame_store[3]);
    dat_hi  = hex_nibble(frame_store[4]);
    dat_lo  = hex_nibble(frame_store[5]);
    cmd_val = {cmd_hi.val, cmd_lo.val};
    dat_val = {dat_hi.val, dat_lo.val};
  end

  always_comb begin
    rx_byte_hit_start = (b == start_byte);
    rx_byte_hit_end   = (b == end_byte);
    receiving_next    = receiving;
    byte_count_next   = byte_count;
    emit              = 1'b0;
    store_wr          = 1'b0;
    new_word          = '{status: ST_OK, command: 8'd0, payload: 8'd0};
    priority if (!receiving) begin
      if (rx_byte_hit_start) begin
        receiving_next  = 1'b1;
        byte_count_next = '0;
      end
    end else if (rx_byte_hit_start) begin
      byte_count_next = '0;
    end else if (rx_byte_hit_end) begin
      receiving_next  = 1'b0;
      byte_count_next = '0;
      emit            = 1'b1;
      priority if (byte_count != CNT_W'(FRAME_LEN)) begin
        new_word.status = ST_LENGTH;
      end else if (frame_store[0] != own_address || frame_store[1] != peer_address) begin
        new_word.status = ST_ADDRESS;
      end else if (!(cmd_hi.ok && cmd_lo.ok)) begin
        new_word.status = ST_CMD_HEX;
      end else if (!(dat_hi.ok && dat_lo.ok)) begin
        new_word.status = ST_DATA_HEX;
      end else if (!in_class(cmd_val, command_class)) begin
        new_word.status = ST_RANGE;
      end else begin
        new_word.command = cmd_val;
        new_word.payload = (cmd_val != 8'd0) ? dat_val : 8'd0;
      end
    end else begin
      store_wr = (byte_count < CNT_W'(FRAME_LEN));
      if (byte_count == CNT_W'(BUFFER_SIZE - 1)) begin
        receiving_next  = 1'b0;
        byte_count_next = '0;
        emit            = 1'b1;
        new_word.status = ST_OVERFLOW;
      end else begin
        byte_count_next = byte_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving  <= 1'b0;
      byte_count <= '0;
    end else if (accept) begin
      receiving  <= receiving_next;
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_wr) begin
      frame_store[byte_count[STORE_IDX_W-1:0]] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept && emit) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      if (!out_valid || take) begin
        out_word <= new_word;
      end else begin
        skid_word <= new_word;
      end
    end else if (take && skid_valid) begin
      out_word <= skid_word;
    end
  end

endmodule

// ===== sv/ahfr_checker.sv =====
// Port-level checker for the ASCII hex frame receiver, with its bind.
// Depends on ahfr_pkg and ascii_hex_frame_receiver_unit_assert.svh.
`include "ascii_hex_frame_receiver_unit_assert.svh"

module ahfr_checker
  import ahfr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] res_status,
  input logic [7:0] res_command,
  input logic [7:0] res_payload
);

  `AHFR_ASSERT_NEXT_ALWAYS(a_reset_empties, clk, rst, !res_valid)
  `AHFR_ASSERT_NEXT(a_stall_holds, clk, rst, res_valid && !res_ready, res_valid && $stable({res_status, res_command, res_payload}))
  `AHFR_ASSERT_IMPLY(a_error_zero, clk, rst, res_valid && res_status != ST_OK, res_command == 8'd0 && res_payload == 8'd0)
  `AHFR_ASSERT_IMPLY(a_zero_cmd_zero_data, clk, rst, res_valid && res_command == 8'd0, res_payload == 8'd0)

endmodule

bind ascii_hex_frame_receiver_unit ahfr_checker u_ahfr_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_status  (res.data.status),
  .res_command (res.data.command),
  .res_payload (res.data.payload)
);
